@@ src/tksel_pkg.sv @@
// ---------------------------------------------------------------------------
// tksel_pkg: shared types for the top-K largest selector
// Word formats, controller states and the control/status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tksel_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned RANK_W  = 4;

  typedef struct packed {
    logic [ID_W-1:0]    item_id;
    logic [VALUE_W-1:0] item_value;
    logic               end_of_set;
  } in_word_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [ID_W-1:0]    out_id;
    logic [VALUE_W-1:0] out_value;
    logic               last_of_run;
  } out_word_t;

  typedef enum logic {
    ST_COLLECT,
    ST_READOUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic insert;      // place the accepted word into the chain
    logic start_rank;  // readout follows: rank counter back to 1
    logic advance;     // head taken: shift the chain toward the head
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_entry;  // head is the final kept entry
  } dp_status_t;

endpackage

@@ src/tksel_ctrl.sv @@
// ---------------------------------------------------------------------------
// tksel_ctrl: controller for the top-K largest selector
// Collects words until the end-of-set word, then walks the readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_eos_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  tksel_pkg::dp_status_t status_i,
  output tksel_pkg::dp_cmd_t    cmd_o
);

  tksel_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tksel_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tksel_pkg::ST_COLLECT: begin
        if (in_valid_i && in_eos_i) begin
          state_d = tksel_pkg::ST_READOUT;
        end
      end
      tksel_pkg::ST_READOUT: begin
        if (out_ready_i && status_i.last_entry) begin
          state_d = tksel_pkg::ST_COLLECT;
        end
      end
      default: state_d = tksel_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      tksel_pkg::ST_COLLECT: begin
        in_ready_o       = 1'b1;
        cmd_o.insert     = in_valid_i;
        cmd_o.start_rank = in_valid_i && in_eos_i;
      end
      tksel_pkg::ST_READOUT: begin
        // head is always valid here: the chain is non-empty once the end-of-set word is offered
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ src/tksel_chain.sv @@
// ---------------------------------------------------------------------------
// tksel_chain: sorted compare-and-shift chain for the top-K selector
// Slots hold entries largest first; insert places a word after all entries
// with an equal or greater count, readout shifts entries out of the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_chain #(
  parameter int unsigned KeepCount = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tksel_pkg::in_word_t   in_word_i,
  input  tksel_pkg::dp_cmd_t    cmd_i,
  output tksel_pkg::dp_status_t status_o,
  output tksel_pkg::out_word_t  out_word_o
);

  logic [tksel_pkg::VALUE_W-1:0] val_q [KeepCount];
  logic [tksel_pkg::ID_W-1:0]    id_q  [KeepCount];
  logic [KeepCount-1:0]          vld_q;
  logic [KeepCount:0]            vld_ext;
  logic [KeepCount-1:0]          keep;
  logic [tksel_pkg::RANK_W-1:0]  rank_q;

  assign vld_ext = {1'b0, vld_q};

  // keep[i]: slot i holds a count >= the new one; a prefix of ones
  always_comb begin
    for (int i = 0; i < KeepCount; i++) begin
      keep[i] = vld_q[i] && (val_q[i] >= in_word_i.item_value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.insert) begin
      for (int i = 0; i < KeepCount; i++) begin
        if (!keep[i]) begin
          if (i == 0) begin
            vld_q[i] <= 1'b1;
          end else if (keep[i-1]) begin
            vld_q[i] <= 1'b1;
          end else begin
            vld_q[i] <= vld_q[i-1];
          end
        end
      end
    end else if (cmd_i.advance) begin
      vld_q <= vld_ext[KeepCount:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      for (int i = 0; i < KeepCount; i++) begin
        if (!keep[i]) begin
          if (i == 0) begin
            val_q[i] <= in_word_i.item_value;
            id_q[i]  <= in_word_i.item_id;
          end else if (keep[i-1]) begin
            val_q[i] <= in_word_i.item_value;
            id_q[i]  <= in_word_i.item_id;
          end else begin
            val_q[i] <= val_q[i-1];
            id_q[i]  <= id_q[i-1];
          end
        end
      end
    end else if (cmd_i.advance) begin
      for (int i = 0; i + 1 < KeepCount; i++) begin
        val_q[i] <= val_q[i+1];
        id_q[i]  <= id_q[i+1];
      end
    end
  end

  // rank wraps at its field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= tksel_pkg::RANK_W'(1);
    end else if (cmd_i.start_rank) begin
      rank_q <= tksel_pkg::RANK_W'(1);
    end else if (cmd_i.advance) begin
      rank_q <= rank_q + tksel_pkg::RANK_W'(1);
    end
  end

  assign status_o.last_entry     = !vld_ext[1];
  assign out_word_o.rank         = rank_q;
  assign out_word_o.out_id       = id_q[0];
  assign out_word_o.out_value    = val_q[0];
  assign out_word_o.last_of_run  = !vld_ext[1];

endmodule

@@ src/top_k_largest_selector_top.sv @@
// ---------------------------------------------------------------------------
// top_k_largest_selector_top: keeps the K largest counts of a word stream
// Sorted insertion chain with a readout controller.
// ---------------------------------------------------------------------------
// Each input word is inserted into a sorted chain of KeepCount slots, so
// words stream in at one per clock while collecting. A word with
// end_of_set is inserted like the others, then input stalls while the kept
// entries leave, largest first, one per cycle at the output handshake, the
// chain shifting one slot per taken word; the chain is empty afterward.
// Equal counts keep arrival order; a full chain drops a new count that is
// not strictly greater than its smallest entry.
`timescale 1ns / 1ps

module top_k_largest_selector_top #(
  parameter int unsigned KeepCount = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tksel_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tksel_pkg::out_word_t out_word_o
);

  tksel_pkg::dp_cmd_t    cmd;
  tksel_pkg::dp_status_t status;

  tksel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_eos_i   (in_word_i.end_of_set),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tksel_chain #(
    .KeepCount(KeepCount)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_word_o(out_word_o)
  );

  // input and readout never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during readout");

  // end-of-set word starts a readout in the next cycle
  a_eos_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.end_of_set) |=> out_valid_o)
    else $error("no readout after end of set");

  // readout opens at rank 1
  a_first_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_word_o.rank == tksel_pkg::RANK_W'(1)))
    else $error("readout does not start at rank 1");

  // the final word ends the readout and frees the input
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_word_o.last_of_run) |=>
      (in_ready_o && !out_valid_o))
    else $error("readout did not end on last word");

endmodule
